### rtl/pawi_pkg.sv
// Package of constants and codes shared by the palette interpolator files.
package pawi_pkg;

    localparam int MAX_ENTRIES_DEF = 256;
    localparam int FRAC_BITS_DEF   = 8;
    localparam int CFG_W           = 9;
    localparam logic [CFG_W-1:0] PALETTE_SIZE_RST = 9'd16;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_LOOKUP = 1'b1
    } opcode_t;

endpackage

### rtl/palette_alpha_weighted_interpolator.sv
// Top level of the alpha-weighted palette interpolator.
//
// Usage: items arrive on the s_ channel (valid/ready). A write item
// (opcode 0) stores one RGBA entry; a lookup item (opcode 1) yields one
// result transfer on the m_ channel, a write yields none. The palette
// size register is loaded through cfg_we/cfg_wdata; the user must load it
// only while the block is idle, which the block itself does not enforce.
// One item is taken every cycle while the receiver does not stall. A lookup
// passes the input register (loaded at the transfer), eight stages of the
// index modulo (up to two conditional subtracts each), the palette read, a
// weight stage, nine pipelined divider stages and then the output register.
// Two copies of the palette RAM give both entries in one read.
// Items pass the RAM stage in order, so a write is seen by every later
// lookup without forwarding.
// Reset clears all valid flags and sets the palette size to 16; palette
// contents are undefined until written. When the receiver stalls the
// whole pipeline freezes and s_ready falls in the same cycle.
module palette_alpha_weighted_interpolator #(
    parameter int MAX_ENTRIES = pawi_pkg::MAX_ENTRIES_DEF,
    parameter int FRAC_BITS   = pawi_pkg::FRAC_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [pawi_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_opcode,
    input  logic [7:0]                 s_entry_index,
    input  logic [7:0]                 s_red_in,
    input  logic [7:0]                 s_green_in,
    input  logic [7:0]                 s_blue_in,
    input  logic [7:0]                 s_alpha_in,
    input  logic signed [15:0]         s_position_int,
    input  logic [7:0]                 s_position_frac,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [7:0]                 m_red_out,
    output logic [7:0]                 m_green_out,
    output logic [7:0]                 m_blue_out,
    output logic [7:0]                 m_alpha_out
);

    localparam int AW   = $clog2(MAX_ENTRIES);
    localparam int FB   = FRAC_BITS;
    localparam int MS   = 8;
    localparam int WW   = FB + 9;
    localparam int SW   = FB + 10;
    localparam int NUMW = FB + 18;
    localparam int DS   = 8;

    logic advance;
    logic [pawi_pkg::CFG_W-1:0] size_reg;
    logic [pawi_pkg::CFG_W-1:0] live_n;

    // Modulo pipeline.
    logic        v_reg    [MS+1];
    logic        op_reg   [MS+1];
    logic [15:0] rem_reg  [MS+1];
    logic [15:0] rem_next [MS+1];
    logic [FB-1:0] fr_reg [MS+1];
    logic [31:0] wd_reg   [MS+1];
    logic [7:0]  wi_reg   [MS+1];

    logic [FB+7:0] frac_ext;
    logic [FB-1:0] frac_in;

    // RAM stage.
    logic [8:0]  i1, i2;
    logic [9:0]  i1_inc;
    logic [AW+8:0] i1_ext, i2_ext;
    logic [AW+7:0] wi_ext;
    logic        ram_re, ram_we;
    logic [31:0] rd_a, rd_b;
    logic        r_v_reg;
    logic [FB-1:0] r_fr_reg;

    // Weight stage.
    logic [FB:0]  k1, k2;
    logic [WW-1:0] w1, w2;
    logic        w_v_reg;
    logic [WW-1:0] w1_reg, w2_reg;
    logic [23:0] ca_reg, cb_reg;

    // Divider pipeline.
    logic            d_v_reg   [DS+1];
    logic [NUMW-1:0] d_num_reg [DS+1][3];
    logic [NUMW-1:0] d_num_next[DS+1][3];
    logic [7:0]      d_q_reg   [DS+1][3];
    logic [7:0]      d_q_next  [DS+1][3];
    logic [SW-1:0]   d_sum_reg [DS+1];
    logic [SW-1:0]   w_sum;

    logic [7:0] red_reg, green_reg, blue_reg, alpha_reg;
    logic       m_valid_reg;

    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance;

    always_comb begin
        if (size_reg == '0) begin
            live_n = pawi_pkg::CFG_W'(1);
        end else if (13'(size_reg) > 13'(MAX_ENTRIES)) begin
            live_n = pawi_pkg::CFG_W'(MAX_ENTRIES);
        end else begin
            live_n = size_reg;
        end
    end

    assign frac_ext = {{FB{1'b0}}, s_position_frac};
    assign frac_in  = frac_ext[FB-1:0];

    // Each modulo stage removes the divisor at two shift positions (the last stage at one).
    always_comb begin
        logic [24:0] dk;
        int          k;
        for (int j = 0; j <= MS; j++) begin
            rem_next[j] = rem_reg[j];
        end
        for (int j = 0; j < MS; j++) begin
            for (int t = 0; t < 2; t++) begin
                k = 14 - 2 * j - t;
                if (k >= 0) begin
                    dk = 25'(live_n) << k;
                    if (25'(rem_next[j]) >= dk) begin
                        rem_next[j] = rem_next[j] - dk[15:0];
                    end
                end
            end
        end
    end

    assign i1     = rem_reg[MS][8:0];
    assign i1_inc = 10'(i1) + 10'd1;
    assign i2     = (i1_inc == 10'(live_n)) ? 9'd0 : i1_inc[8:0];
    assign i1_ext = {{AW{1'b0}}, i1};
    assign i2_ext = {{AW{1'b0}}, i2};
    assign wi_ext = {{AW{1'b0}}, wi_reg[MS]};

    assign ram_re = advance && v_reg[MS] && (op_reg[MS] == pawi_pkg::OP_LOOKUP);
    assign ram_we = advance && v_reg[MS] && (op_reg[MS] == pawi_pkg::OP_WRITE)
                    && (13'(wi_reg[MS]) < 13'(MAX_ENTRIES));

    pawi_ram #(.WIDTH(32), .DEPTH(MAX_ENTRIES)) u_ram_a (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wi_ext[AW-1:0]),
        .wdata (wd_reg[MS]),
        .re    (ram_re),
        .raddr (i1_ext[AW-1:0]),
        .rdata (rd_a)
    );

    pawi_ram #(.WIDTH(32), .DEPTH(MAX_ENTRIES)) u_ram_b (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wi_ext[AW-1:0]),
        .wdata (wd_reg[MS]),
        .re    (ram_re),
        .raddr (i2_ext[AW-1:0]),
        .rdata (rd_b)
    );

    assign k2 = {1'b0, r_fr_reg};
    assign k1 = ((FB+1)'(1) << FB) - k2;
    assign w1 = WW'(k1) * WW'(rd_a[31:24]);
    assign w2 = WW'(k2) * WW'(rd_b[31:24]);
    assign w_sum = SW'(w1_reg) + SW'(w2_reg);

    // One quotient bit per divider stage; the quotient never exceeds 255.
    always_comb begin
        logic [NUMW-1:0] dv;
        for (int j = 0; j <= DS; j++) begin
            for (int c = 0; c < 3; c++) begin
                d_num_next[j][c] = d_num_reg[j][c];
                d_q_next[j][c]   = d_q_reg[j][c];
            end
        end
        for (int j = 0; j < DS; j++) begin
            dv = NUMW'(d_sum_reg[j]) << (7 - j);
            for (int c = 0; c < 3; c++) begin
                if (d_num_reg[j][c] >= dv) begin
                    d_num_next[j][c] = d_num_reg[j][c] - dv;
                    d_q_next[j][c]   = {d_q_reg[j][c][6:0], 1'b1};
                end else begin
                    d_q_next[j][c]   = {d_q_reg[j][c][6:0], 1'b0};
                end
            end
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg    <= pawi_pkg::PALETTE_SIZE_RST;
            m_valid_reg <= 1'b0;
            r_v_reg     <= 1'b0;
            w_v_reg     <= 1'b0;
            for (int j = 0; j <= MS; j++) begin
                v_reg[j] <= 1'b0;
            end
            for (int j = 0; j <= DS; j++) begin
                d_v_reg[j] <= 1'b0;
            end
        end else begin
            if (cfg_we) begin
                size_reg <= cfg_wdata;
            end
            if (advance) begin
                v_reg[0] <= s_valid;
                for (int j = 1; j <= MS; j++) begin
                    v_reg[j] <= v_reg[j-1];
                end
                r_v_reg    <= v_reg[MS] && (op_reg[MS] == pawi_pkg::OP_LOOKUP);
                w_v_reg    <= r_v_reg;
                d_v_reg[0] <= w_v_reg;
                for (int j = 1; j <= DS; j++) begin
                    d_v_reg[j] <= d_v_reg[j-1];
                end
                m_valid_reg <= d_v_reg[DS];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (advance) begin
            op_reg[0] <= s_opcode;
            wi_reg[0] <= s_entry_index;
            wd_reg[0] <= {s_alpha_in, s_blue_in, s_green_in, s_red_in};
            if (s_position_int < 0) begin
                rem_reg[0] <= 16'd0;
                fr_reg[0]  <= '0;
            end else begin
                rem_reg[0] <= 16'(s_position_int);
                fr_reg[0]  <= frac_in;
            end
            for (int j = 1; j <= MS; j++) begin
                op_reg[j]  <= op_reg[j-1];
                wi_reg[j]  <= wi_reg[j-1];
                wd_reg[j]  <= wd_reg[j-1];
                rem_reg[j] <= rem_next[j-1];
                fr_reg[j]  <= fr_reg[j-1];
            end
            r_fr_reg <= fr_reg[MS];

            w1_reg <= w1;
            w2_reg <= w2;
            ca_reg <= rd_a[23:0];
            cb_reg <= rd_b[23:0];

            d_sum_reg[0] <= w_sum;
            for (int c = 0; c < 3; c++) begin
                d_num_reg[0][c] <= NUMW'(ca_reg[8*c +: 8]) * NUMW'(w1_reg)
                                 + NUMW'(cb_reg[8*c +: 8]) * NUMW'(w2_reg);
                d_q_reg[0][c]   <= 8'd0;
            end
            for (int j = 1; j <= DS; j++) begin
                d_sum_reg[j] <= d_sum_reg[j-1];
                for (int c = 0; c < 3; c++) begin
                    d_num_reg[j][c] <= d_num_next[j-1][c];
                    d_q_reg[j][c]   <= d_q_next[j-1][c];
                end
            end

            // A zero weight sum gives black.
            if (d_sum_reg[DS] == '0) begin
                red_reg   <= 8'd0;
                green_reg <= 8'd0;
                blue_reg  <= 8'd0;
            end else begin
                red_reg   <= d_q_reg[DS][0];
                green_reg <= d_q_reg[DS][1];
                blue_reg  <= d_q_reg[DS][2];
            end
            alpha_reg <= d_sum_reg[DS][FB +: 8];
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_red_out   = red_reg;
    assign m_green_out = green_reg;
    assign m_blue_out  = blue_reg;
    assign m_alpha_out = alpha_reg;

`ifndef NO_ASSERTIONS
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input taken while the result is stalled");

    a_index_wrapped: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_reg[MS] && (op_reg[MS] == pawi_pkg::OP_LOOKUP)) |-> (rem_reg[MS] < 16'(live_n)))
        else $error("palette index not reduced below the palette size");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_alpha_out) && $stable(m_red_out)))
        else $error("stalled result changed");
`endif

endmodule

### rtl/pawi_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module pawi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = pawi_pkg::MAX_ENTRIES_DEF
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        // Read data holds while the read enable is low.
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
